>>> rtl/ipow_pkg.sv
// Shared types, constants and the control program of the integer power sequencer.
package ipow_pkg;

    // The overflow threshold is 2^EXP_BITS; exponents at or above it take the fixed rule.
    localparam int EXP_BITS = 6;
    localparam int UPC_BITS = 3;

    // Program addresses.
    localparam logic [UPC_BITS-1:0] UPC_DISPATCH = 3'd0;
    localparam logic [UPC_BITS-1:0] UPC_MUL      = 3'd1;
    localparam logic [UPC_BITS-1:0] UPC_SQUARE   = 3'd4;
    localparam logic [UPC_BITS-1:0] UPC_DONE     = 3'd7;

    // Sequencer state.
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Branch condition of a control word.
    typedef enum logic [1:0] {
        C_NEXT,
        C_JUMP,
        C_DISPATCH,
        C_LAST
    } cond_t;

    // Left multiplier operand.
    typedef enum logic {
        SRC_ACC,
        SRC_BASE
    } src_t;

    // Which partial product of the split multiply this step forms.
    typedef enum logic [1:0] {
        PP_NONE,
        PP_LL,
        PP_LH,
        PP_HL
    } pp_t;

    // Register that takes the finished product.
    typedef enum logic [1:0] {
        D_NONE,
        D_ACC,
        D_BASE
    } dest_t;

    typedef struct packed {
        cond_t                cond;
        logic [UPC_BITS-1:0]  target;
        src_t                 src;
        pp_t                  pp;
        dest_t                dest;
        logic                 shift;
        logic                 done;
    } uword_t;

    // Control program. One round per exponent bit: dispatch, optional multiply
    // of the accumulator by the base, then squaring of the base except on the last bit.
    localparam uword_t UCODE [2**UPC_BITS] = '{
        '{C_DISPATCH, UPC_DONE,     SRC_ACC,  PP_NONE, D_NONE, 1'b0, 1'b0},
        '{C_NEXT,     UPC_DISPATCH, SRC_ACC,  PP_LL,   D_NONE, 1'b0, 1'b0},
        '{C_NEXT,     UPC_DISPATCH, SRC_ACC,  PP_LH,   D_NONE, 1'b0, 1'b0},
        '{C_LAST,     UPC_DONE,     SRC_ACC,  PP_HL,   D_ACC,  1'b0, 1'b0},
        '{C_NEXT,     UPC_DISPATCH, SRC_BASE, PP_LL,   D_NONE, 1'b0, 1'b0},
        '{C_NEXT,     UPC_DISPATCH, SRC_BASE, PP_LH,   D_NONE, 1'b0, 1'b0},
        '{C_JUMP,     UPC_DISPATCH, SRC_BASE, PP_HL,   D_BASE, 1'b1, 1'b0},
        '{C_NEXT,     UPC_DISPATCH, SRC_ACC,  PP_NONE, D_NONE, 1'b0, 1'b1}
    };

endpackage

>>> rtl/integer_power_by_squaring.sv
// Top level: microcoded square-and-multiply power unit with a shared half-width multiplier.

// Computes base^exponent modulo 2^DATA_WIDTH for exponents below 64, sign-extended
// to 64 bits, one word at a time; an exponent of 64 and above gives 1 for a base
// of 1, 1 or all ones by exponent parity for an all-ones base, and 0 otherwise.
// Each full-width product is built from three partial products on one
// (DATA_WIDTH+1)/2-bit multiplier, and that multiplier is what sets the latency.
// An item is loaded, then for each exponent bit up to the highest set one the
// program dispatches, multiplies the accumulator by the base when the bit is set
// and squares the base unless it is the last bit, then hands the result to the
// output register once it has room. A new word is accepted as soon as the
// previous one has reached it, even while that result still waits to be taken.
module integer_power_by_squaring #(
    parameter int DATA_WIDTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_base_value,
    input  logic [7:0]  s_exponent,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_power
);

    localparam int HALF = (DATA_WIDTH + 1) / 2;

    ipow_pkg::state_t                   state_reg, state_next;
    logic [ipow_pkg::UPC_BITS-1:0]      pc_reg, pc_next;
    logic [DATA_WIDTH-1:0]              acc_reg, acc_next;
    logic [DATA_WIDTH-1:0]              base_reg, base_next;
    logic [DATA_WIDTH-1:0]              prod_reg, prod_next;
    logic [ipow_pkg::EXP_BITS-1:0]      exp_reg, exp_next;
    logic                               m_valid_reg, m_valid_next;
    logic [63:0]                        m_power_reg, m_power_next;

    ipow_pkg::uword_t                   uword;
    logic [DATA_WIDTH-1:0]              mul_src;
    logic [HALF-1:0]                    op_a, op_b;
    logic [2*HALF-1:0]                  pp_full;
    logic [DATA_WIDTH-1:0]              pp_lo, pp_shl, prod_sum;
    logic [DATA_WIDTH-1:0]              base_in, rule_value;
    logic                               in_fire, out_free, overflow_in;

    assign uword    = ipow_pkg::UCODE[pc_reg];
    assign s_ready  = (state_reg == ipow_pkg::ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_power  = m_power_reg;

    // Input decode and the fixed answer for exponents of 64 and above.
    assign base_in     = s_base_value[DATA_WIDTH-1:0];
    assign overflow_in = |s_exponent[7:ipow_pkg::EXP_BITS];
    always_comb begin
        priority if (base_in == DATA_WIDTH'(1)) begin
            rule_value = DATA_WIDTH'(1);
        end else if (base_in == {DATA_WIDTH{1'b1}}) begin
            rule_value = s_exponent[0] ? {DATA_WIDTH{1'b1}} : DATA_WIDTH'(1);
        end else begin
            rule_value = '0;
        end
    end

    // Shared half-width multiplier; the step picks which halves meet.
    assign mul_src = (uword.src == ipow_pkg::SRC_ACC) ? acc_reg : base_reg;
    always_comb begin
        unique case (uword.pp)
            ipow_pkg::PP_LH: begin
                op_a = mul_src[HALF-1:0];
                op_b = HALF'(base_reg[DATA_WIDTH-1:HALF]);
            end
            ipow_pkg::PP_HL: begin
                op_a = HALF'(mul_src[DATA_WIDTH-1:HALF]);
                op_b = base_reg[HALF-1:0];
            end
            default: begin
                op_a = mul_src[HALF-1:0];
                op_b = base_reg[HALF-1:0];
            end
        endcase
    end
    assign pp_full  = op_a * op_b;
    assign pp_lo    = pp_full[DATA_WIDTH-1:0];
    assign pp_shl   = pp_lo << HALF;
    assign prod_sum = prod_reg + pp_shl;

    // Sequencer: next state, program counter and datapath writes.
    always_comb begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        acc_next     = acc_reg;
        base_next    = base_reg;
        prod_next    = prod_reg;
        exp_next     = exp_reg;
        m_valid_next = m_valid_reg;
        m_power_next = m_power_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ipow_pkg::ST_IDLE: begin
                if (in_fire) begin
                    base_next  = base_in;
                    pc_next    = ipow_pkg::UPC_DISPATCH;
                    state_next = ipow_pkg::ST_RUN;
                    if (overflow_in) begin
                        acc_next = rule_value;
                        exp_next = '0;
                    end else begin
                        acc_next = DATA_WIDTH'(1);
                        exp_next = s_exponent[ipow_pkg::EXP_BITS-1:0];
                    end
                end
            end
            ipow_pkg::ST_RUN: begin
                // Partial product accumulation and writeback.
                unique case (uword.pp)
                    ipow_pkg::PP_LL: prod_next = pp_lo;
                    ipow_pkg::PP_LH: prod_next = prod_sum;
                    default:         prod_next = prod_reg;
                endcase
                if (uword.pp == ipow_pkg::PP_HL) begin
                    unique case (uword.dest)
                        ipow_pkg::D_ACC:  acc_next  = prod_sum;
                        ipow_pkg::D_BASE: base_next = prod_sum;
                        default:          ;
                    endcase
                end
                if (uword.shift) begin
                    exp_next = exp_reg >> 1;
                end

                // Branch resolution.
                unique case (uword.cond)
                    ipow_pkg::C_JUMP: pc_next = uword.target;
                    ipow_pkg::C_DISPATCH: begin
                        priority if (exp_reg == '0) begin
                            pc_next = uword.target;
                        end else if (!exp_reg[0]) begin
                            pc_next = ipow_pkg::UPC_SQUARE;
                        end else begin
                            pc_next = ipow_pkg::UPC_MUL;
                        end
                    end
                    ipow_pkg::C_LAST: begin
                        if (exp_reg[ipow_pkg::EXP_BITS-1:1] == '0) begin
                            pc_next = uword.target;
                        end else begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                    default: pc_next = pc_reg + 1'b1;
                endcase

                // Final step waits for room in the output register.
                if (uword.done) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_power_next = 64'(signed'(acc_reg));
                        state_next   = ipow_pkg::ST_IDLE;
                    end else begin
                        pc_next = pc_reg;
                    end
                end
            end
            default: state_next = ipow_pkg::ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ipow_pkg::ST_IDLE;
            pc_reg      <= ipow_pkg::UPC_DISPATCH;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        acc_reg     <= acc_next;
        base_reg    <= base_next;
        prod_reg    <= prod_next;
        exp_reg     <= exp_next;
        m_power_reg <= m_power_next;
    end

    // The exponent shifts right by one bit at the end of each squaring.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ipow_pkg::ST_RUN && uword.shift) |=> (exp_reg == ($past(exp_reg) >> 1)))
        else $error("exponent not shifted after squaring");

    // A zero exponent starts with a unit accumulator and nothing left to do.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_exponent == 8'd0) |=> (acc_reg == DATA_WIDTH'(1) && exp_reg == '0))
        else $error("zero exponent not loaded as unit result");

    // A new result appears only from the final program step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ipow_pkg::ST_RUN && uword.done))
        else $error("result presented outside the final step");

    // The sequencer leaves the run state only through the final step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ipow_pkg::ST_RUN && !uword.done) |=> (state_reg == ipow_pkg::ST_RUN))
        else $error("sequencer left run state early");

endmodule
